### src/cau_pkg.sv
// Shared types for the complex arithmetic unit: command codes and the
// per-item flag bundle that travels down the pipeline. No dependencies.
package cau_pkg;

  // Command codes carried in the low bits of the input word
  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_NEG = 3'd4,
    CMD_CMP = 3'd5,
    CMD_INC = 3'd6,
    CMD_DEC = 3'd7
  } cmd_e;

  // Status that rides along with each word
  typedef struct packed {
    cmd_e cmd;
    logic mag_less;
    logic mag_greater;
    logic parts_equal;
    logic a_is_zero;
    logic div_by_zero;
    logic ovf;          // saturation of a non-divide result
    logic big_re;       // divide quotient magnitude at or above 2^W
    logic big_im;
    logic neg_re;       // divide quotient sign
    logic neg_im;
  } flag_t;

endpackage

### src/complex_arith_unit.sv
// Top level of the complex arithmetic unit: stream ports, product, prepare
// and divider pipelines, and the output register. Depends on cau_pkg,
// cau_mul, cau_prep and cau_div.
//
// Usage: one input word carries a command and two complex Q-format operands;
// one output word carries the saturated result parts and six status flags.
// Both sides are valid/ready stream channels; a word moves on a clock edge
// with tvalid and tready high.
// The path is one product stage, two prepare stages, one divider stage per
// quotient bit and the output register. Every command passes through the
// same stages, so words leave in order. Throughput is one word per cycle
// while the receiver keeps taking words.
// Each stage holds its word while the stage after it is full and stalled;
// empty stages keep filling, so a stalled receiver only backs the stream up
// once all stages are occupied. Nothing is dropped or repeated.
// Reset clears all valid bits, so the block is ready once reset is
// released. There is no configuration.
module complex_arith_unit import cau_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // command[2:0], a_re, a_im, b_re, b_im, zero pad to bytes
  input  logic [((4*WORD_BITS+3+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // res_re, res_im, div_by_zero, overflow, mag_less, mag_greater,
  // parts_equal, a_is_zero, zero pad to bytes
  output logic [((2*WORD_BITS+6+7)/8)*8-1:0] m_axis_tdata
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int NW = 2 * W + 1 + F;

  // ---- input unpack ----
  cmd_e                cmd_in;
  logic signed [W-1:0] ar_in, ai_in, br_in, bi_in;

  assign cmd_in = cmd_e'(s_axis_tdata[2:0]);
  assign ar_in  = s_axis_tdata[3 +: W];
  assign ai_in  = s_axis_tdata[3 + W +: W];
  assign br_in  = s_axis_tdata[3 + 2*W +: W];
  assign bi_in  = s_axis_tdata[3 + 3*W +: W];

  // ---- products ----
  logic                  m_valid, m_ready;
  cmd_e                  m_cmd;
  logic signed [W-1:0]   m_ar, m_ai, m_br, m_bi;
  logic signed [2*W-1:0] p_arbr, p_aibi, p_arbi, p_aibr, p_arar, p_aiai, p_brbr, p_bibi;

  cau_mul #(.W(W)) u_mul (
    .clk_i, .rst_ni,
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .cmd_i    (cmd_in),
    .ar_i     (ar_in),
    .ai_i     (ai_in),
    .br_i     (br_in),
    .bi_i     (bi_in),
    .valid_o  (m_valid),
    .ready_i  (m_ready),
    .cmd_o    (m_cmd),
    .ar_o     (m_ar),
    .ai_o     (m_ai),
    .br_o     (m_br),
    .bi_o     (m_bi),
    .p_arbr_o (p_arbr),
    .p_aibi_o (p_aibi),
    .p_arbi_o (p_arbi),
    .p_aibr_o (p_aibr),
    .p_arar_o (p_arar),
    .p_aiai_o (p_aiai),
    .p_brbr_o (p_brbr),
    .p_bibi_o (p_bibi)
  );

  // ---- sums, saturation, divider operands ----
  logic           p_valid, p_ready;
  logic [W-1:0]   p_res_re, p_res_im;
  logic [NW-1:0]  p_num_re, p_num_im;
  logic [2*W-1:0] p_den;
  flag_t          p_flags;

  cau_prep #(.W(W), .F(F)) u_prep (
    .clk_i, .rst_ni,
    .valid_i  (m_valid),
    .ready_o  (m_ready),
    .cmd_i    (m_cmd),
    .ar_i     (m_ar),
    .ai_i     (m_ai),
    .br_i     (m_br),
    .bi_i     (m_bi),
    .p_arbr_i (p_arbr),
    .p_aibi_i (p_aibi),
    .p_arbi_i (p_arbi),
    .p_aibr_i (p_aibr),
    .p_arar_i (p_arar),
    .p_aiai_i (p_aiai),
    .p_brbr_i (p_brbr),
    .p_bibi_i (p_bibi),
    .valid_o  (p_valid),
    .ready_i  (p_ready),
    .res_re_o (p_res_re),
    .res_im_o (p_res_im),
    .num_re_o (p_num_re),
    .num_im_o (p_num_im),
    .den_o    (p_den),
    .flags_o  (p_flags)
  );

  // ---- divider ----
  logic         d_valid, d_ready;
  logic [W-1:0] d_q_re, d_q_im, d_res_re, d_res_im;
  flag_t        d_flags;

  cau_div #(.W(W), .F(F)) u_div (
    .clk_i, .rst_ni,
    .valid_i  (p_valid),
    .ready_o  (p_ready),
    .num_re_i (p_num_re),
    .num_im_i (p_num_im),
    .den_i    (p_den),
    .res_re_i (p_res_re),
    .res_im_i (p_res_im),
    .flags_i  (p_flags),
    .valid_o  (d_valid),
    .ready_i  (d_ready),
    .q_re_o   (d_q_re),
    .q_im_o   (d_q_im),
    .res_re_o (d_res_re),
    .res_im_o (d_res_im),
    .flags_o  (d_flags)
  );

  // ---- quotient sign and saturation ----
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  // returns {overflow, value}
  function automatic logic [W:0] div_sat(input logic [W-1:0] q, input logic neg,
                                         input logic big);
    logic [W:0] r;
    if (big) begin
      r = {1'b1, neg ? MINV : MAXV};
    end else if (neg) begin
      r = (q > MINV) ? {1'b1, MINV} : {1'b0, W'(-q)};
    end else begin
      r = q[W-1] ? {1'b1, MAXV} : {1'b0, q};
    end
    return r;
  endfunction

  logic [W:0]   dre_sat, dim_sat;
  logic [W-1:0] res_re_d, res_im_d;
  logic         ovf_d;

  assign dre_sat = div_sat(d_q_re, d_flags.neg_re, d_flags.big_re);
  assign dim_sat = div_sat(d_q_im, d_flags.neg_im, d_flags.big_im);

  always_comb begin
    if (d_flags.cmd != CMD_DIV) begin
      res_re_d = d_res_re;
      res_im_d = d_res_im;
      ovf_d    = d_flags.ovf;
    end else if (d_flags.div_by_zero) begin
      res_re_d = '0;
      res_im_d = '0;
      ovf_d    = 1'b0;
    end else begin
      res_re_d = dre_sat[W-1:0];
      res_im_d = dim_sat[W-1:0];
      ovf_d    = dre_sat[W] || dim_sat[W];
    end
  end

  // ---- output register ----
  logic         vo_q;
  logic [W-1:0] res_re_q, res_im_q;
  logic         dz_q, ovf_q, less_q, greater_q, eq_q, az_q;

  assign d_ready = !vo_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (d_ready) begin
      vo_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_ready && d_valid) begin
      res_re_q  <= res_re_d;
      res_im_q  <= res_im_d;
      dz_q      <= d_flags.div_by_zero;
      ovf_q     <= ovf_d;
      less_q    <= d_flags.mag_less;
      greater_q <= d_flags.mag_greater;
      eq_q      <= d_flags.parts_equal;
      az_q      <= d_flags.a_is_zero;
    end
  end

  assign m_axis_tvalid = vo_q;

  always_comb begin
    m_axis_tdata              = '0;
    m_axis_tdata[W-1:0]       = res_re_q;
    m_axis_tdata[2*W-1:W]     = res_im_q;
    m_axis_tdata[2*W]         = dz_q;
    m_axis_tdata[2*W+1]       = ovf_q;
    m_axis_tdata[2*W+2]       = less_q;
    m_axis_tdata[2*W+3]       = greater_q;
    m_axis_tdata[2*W+4]       = eq_q;
    m_axis_tdata[2*W+5]       = az_q;
  end

  // ---- checks ----
  a_dz_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && dz_q) |-> (!ovf_q && res_re_q == '0 && res_im_q == '0))
    else $error("divide by zero result not cleared");

  a_mag_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q |-> !(less_q && greater_q))
    else $error("magnitude flags both set");

  a_eq_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && eq_q) |-> (!less_q && !greater_q))
    else $error("equal operands with unequal magnitudes");

  a_zero_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && az_q) |-> !greater_q)
    else $error("zero operand reported larger");

endmodule

### src/cau_mul.sv
// Product stage of the complex arithmetic unit: one registered stage with
// the eight operand products. Depends on cau_pkg.
module cau_mul import cau_pkg::*; #(
  parameter int W = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  cmd_e                  cmd_i,
  input  logic signed [W-1:0]   ar_i,
  input  logic signed [W-1:0]   ai_i,
  input  logic signed [W-1:0]   br_i,
  input  logic signed [W-1:0]   bi_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output cmd_e                  cmd_o,
  output logic signed [W-1:0]   ar_o,
  output logic signed [W-1:0]   ai_o,
  output logic signed [W-1:0]   br_o,
  output logic signed [W-1:0]   bi_o,
  output logic signed [2*W-1:0] p_arbr_o,
  output logic signed [2*W-1:0] p_aibi_o,
  output logic signed [2*W-1:0] p_arbi_o,
  output logic signed [2*W-1:0] p_aibr_o,
  output logic signed [2*W-1:0] p_arar_o,
  output logic signed [2*W-1:0] p_aiai_o,
  output logic signed [2*W-1:0] p_brbr_o,
  output logic signed [2*W-1:0] p_bibi_o
);

  logic rdy;
  logic v_q;

  assign rdy     = !v_q || ready_i;
  assign ready_o = rdy;
  assign valid_o = v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy) begin
      v_q <= valid_i;
    end
  end

  // Products registered straight out of the multipliers
  always_ff @(posedge clk_i) begin
    if (rdy && valid_i) begin
      cmd_o    <= cmd_i;
      ar_o     <= ar_i;
      ai_o     <= ai_i;
      br_o     <= br_i;
      bi_o     <= bi_i;
      p_arbr_o <= ar_i * br_i;
      p_aibi_o <= ai_i * bi_i;
      p_arbi_o <= ar_i * bi_i;
      p_aibr_o <= ai_i * br_i;
      p_arar_o <= ar_i * ar_i;
      p_aiai_o <= ai_i * ai_i;
      p_brbr_o <= br_i * br_i;
      p_bibi_o <= bi_i * bi_i;
    end
  end

endmodule

### src/cau_prep.sv
// Sum and prepare stages of the complex arithmetic unit: product sums,
// simple results with saturation, magnitude compare, divider operands.
// Depends on cau_pkg.
module cau_prep import cau_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  cmd_e                  cmd_i,
  input  logic signed [W-1:0]   ar_i,
  input  logic signed [W-1:0]   ai_i,
  input  logic signed [W-1:0]   br_i,
  input  logic signed [W-1:0]   bi_i,
  input  logic signed [2*W-1:0] p_arbr_i,
  input  logic signed [2*W-1:0] p_aibi_i,
  input  logic signed [2*W-1:0] p_arbi_i,
  input  logic signed [2*W-1:0] p_aibr_i,
  input  logic signed [2*W-1:0] p_arar_i,
  input  logic signed [2*W-1:0] p_aiai_i,
  input  logic signed [2*W-1:0] p_brbr_i,
  input  logic signed [2*W-1:0] p_bibi_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [W-1:0]          res_re_o,
  output logic [W-1:0]          res_im_o,
  output logic [2*W+F:0]        num_re_o,
  output logic [2*W+F:0]        num_im_o,
  output logic [2*W-1:0]        den_o,
  output flag_t                 flags_o
);

  localparam int SW = 2 * W + 1;
  localparam int XW = W + 2;
  localparam int NW = SW + F;
  localparam int CW = NW + W + 1;
  localparam logic signed [XW-1:0] ONE  = XW'(1) <<< F;
  localparam logic signed [SW-1:0] SMAX = (SW'(1) <<< (W - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SMIN = -(SW'(1) <<< (W - 1));

  logic rdy_b, rdy_c;
  logic vb_q, vc_q;

  assign rdy_c   = !vc_q || ready_i;
  assign rdy_b   = !vb_q || rdy_c;
  assign ready_o = rdy_b;
  assign valid_o = vc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_b) vb_q <= valid_i;
      if (rdy_c) vc_q <= vb_q;
    end
  end

  // ---- stage B: sums and simple results ----
  logic signed [XW-1:0] ar_x, ai_x, br_x, bi_x;
  logic signed [XW-1:0] smp_re_d, smp_im_d, smp_re_q, smp_im_q;
  logic signed [SW-1:0] mre_d, mim_d, dre_d, dim_d, maga_d, magb_d;
  logic signed [SW-1:0] mre_q, mim_q, dre_q, dim_q, maga_q, magb_q;
  cmd_e                 cmd_b_q;
  logic                 eq_q, az_q;

  assign ar_x = XW'(ar_i);
  assign ai_x = XW'(ai_i);
  assign br_x = XW'(br_i);
  assign bi_x = XW'(bi_i);

  always_comb begin
    smp_re_d = '0;
    smp_im_d = '0;
    case (cmd_i)
      CMD_ADD: begin smp_re_d = ar_x + br_x; smp_im_d = ai_x + bi_x; end
      CMD_SUB: begin smp_re_d = ar_x - br_x; smp_im_d = ai_x - bi_x; end
      CMD_NEG: begin smp_re_d = -ar_x;       smp_im_d = -ai_x;       end
      CMD_INC: begin smp_re_d = ar_x + ONE;  smp_im_d = ai_x;        end
      CMD_DEC: begin smp_re_d = ar_x - ONE;  smp_im_d = ai_x;        end
      default: begin smp_re_d = '0;          smp_im_d = '0;          end
    endcase
  end

  assign mre_d  = SW'(p_arbr_i) - SW'(p_aibi_i);
  assign mim_d  = SW'(p_arbi_i) + SW'(p_aibr_i);
  assign dre_d  = SW'(p_arbr_i) + SW'(p_aibi_i);
  assign dim_d  = SW'(p_aibr_i) - SW'(p_arbi_i);
  assign maga_d = SW'(p_arar_i) + SW'(p_aiai_i);
  assign magb_d = SW'(p_brbr_i) + SW'(p_bibi_i);

  always_ff @(posedge clk_i) begin
    if (rdy_b && valid_i) begin
      cmd_b_q  <= cmd_i;
      smp_re_q <= smp_re_d;
      smp_im_q <= smp_im_d;
      mre_q    <= mre_d;
      mim_q    <= mim_d;
      dre_q    <= dre_d;
      dim_q    <= dim_d;
      maga_q   <= maga_d;
      magb_q   <= magb_d;
      eq_q     <= (ar_i == br_i) && (ai_i == bi_i);
      az_q     <= (ar_i == '0) && (ai_i == '0);
    end
  end

  // ---- stage C: saturate, compare, divider operands ----
  logic signed [SW-1:0] wre, wim;
  logic                 ovf_re, ovf_im;
  logic [W-1:0]         res_re_d, res_im_d;
  logic signed [NW-1:0] nre, nim;
  logic [NW-1:0]        mag_re, mag_im;
  logic [2*W-1:0]       den_d;
  flag_t                flg_d;

  always_comb begin
    if (cmd_b_q == CMD_MUL) begin
      wre = mre_q >>> F;
      wim = mim_q >>> F;
    end else begin
      wre = SW'(smp_re_q);
      wim = SW'(smp_im_q);
    end
  end

  assign ovf_re   = (wre > SMAX) || (wre < SMIN);
  assign ovf_im   = (wim > SMAX) || (wim < SMIN);
  assign res_re_d = ovf_re ? ((wre > SMAX) ? SMAX[W-1:0] : SMIN[W-1:0]) : wre[W-1:0];
  assign res_im_d = ovf_im ? ((wim > SMAX) ? SMAX[W-1:0] : SMIN[W-1:0]) : wim[W-1:0];

  // Divider numerators as sign and magnitude
  assign nre    = NW'(dre_q) <<< F;
  assign nim    = NW'(dim_q) <<< F;
  assign mag_re = nre[NW-1] ? NW'(-nre) : NW'(nre);
  assign mag_im = nim[NW-1] ? NW'(-nim) : NW'(nim);
  assign den_d  = magb_q[2*W-1:0];

  always_comb begin
    flg_d             = '0;
    flg_d.cmd         = cmd_b_q;
    flg_d.mag_less    = maga_q < magb_q;
    flg_d.mag_greater = maga_q > magb_q;
    flg_d.parts_equal = eq_q;
    flg_d.a_is_zero   = az_q;
    flg_d.div_by_zero = (cmd_b_q == CMD_DIV) && (magb_q == '0);
    flg_d.ovf         = ovf_re || ovf_im;
    flg_d.big_re      = CW'(mag_re) >= (CW'(den_d) << W);
    flg_d.big_im      = CW'(mag_im) >= (CW'(den_d) << W);
    flg_d.neg_re      = nre[NW-1];
    flg_d.neg_im      = nim[NW-1];
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && vb_q) begin
      res_re_o <= res_re_d;
      res_im_o <= res_im_d;
      num_re_o <= mag_re;
      num_im_o <= mag_im;
      den_o    <= den_d;
      flags_o  <= flg_d;
    end
  end

endmodule

### src/cau_div.sv
// Pipelined restoring divider of the complex arithmetic unit: W stages,
// one quotient bit per lane per stage, both lanes sharing the denominator.
// Depends on cau_pkg.
module cau_div import cau_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic [2*W+F:0] num_re_i,
  input  logic [2*W+F:0] num_im_i,
  input  logic [2*W-1:0] den_i,
  input  logic [W-1:0]   res_re_i,
  input  logic [W-1:0]   res_im_i,
  input  flag_t          flags_i,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [W-1:0]   q_re_o,
  output logic [W-1:0]   q_im_o,
  output logic [W-1:0]   res_re_o,
  output logic [W-1:0]   res_im_o,
  output flag_t          flags_o
);

  localparam int NW = 2 * W + 1 + F;
  localparam int CW = NW + W + 1;

  logic           v   [W+1];
  logic           rdy [1:W+1];
  logic [NW-1:0]  rre [W+1];
  logic [NW-1:0]  rim [W+1];
  logic [W-1:0]   qre [W+1];
  logic [W-1:0]   qim [W+1];
  logic [2*W-1:0] den [W+1];
  logic [W-1:0]   sre [W+1];
  logic [W-1:0]   sim [W+1];
  flag_t          flg [W+1];

  assign v[0]   = valid_i;
  assign rre[0] = num_re_i;
  assign rim[0] = num_im_i;
  assign qre[0] = '0;
  assign qim[0] = '0;
  assign den[0] = den_i;
  assign sre[0] = res_re_i;
  assign sim[0] = res_im_i;
  assign flg[0] = flags_i;
  assign rdy[W+1] = ready_i;
  assign ready_o  = rdy[1];

  for (genvar s = 0; s < W; s++) begin : g_stage
    localparam int B = W - 1 - s;
    logic          v_q;
    logic [CW-1:0] t_re, t_im;
    logic [NW-1:0] rre_d, rim_d, rre_q, rim_q;
    logic [W-1:0]  qre_d, qim_d, qre_q, qim_q;
    logic [2*W-1:0] den_q;
    logic [W-1:0]  sre_q, sim_q;
    flag_t         flg_q;

    // Trial subtract of the shifted denominator
    assign t_re = CW'(rre[s]) - (CW'(den[s]) << B);
    assign t_im = CW'(rim[s]) - (CW'(den[s]) << B);

    always_comb begin
      rre_d    = t_re[CW-1] ? rre[s] : t_re[NW-1:0];
      rim_d    = t_im[CW-1] ? rim[s] : t_im[NW-1:0];
      qre_d    = qre[s];
      qim_d    = qim[s];
      qre_d[B] = !t_re[CW-1];
      qim_d[B] = !t_im[CW-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (rdy[s+1]) begin
        v_q <= v[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s+1] && v[s]) begin
        rre_q <= rre_d;
        rim_q <= rim_d;
        qre_q <= qre_d;
        qim_q <= qim_d;
        den_q <= den[s];
        sre_q <= sre[s];
        sim_q <= sim[s];
        flg_q <= flg[s];
      end
    end

    assign rdy[s+1] = !v_q || rdy[s+2];
    assign v[s+1]   = v_q;
    assign rre[s+1] = rre_q;
    assign rim[s+1] = rim_q;
    assign qre[s+1] = qre_q;
    assign qim[s+1] = qim_q;
    assign den[s+1] = den_q;
    assign sre[s+1] = sre_q;
    assign sim[s+1] = sim_q;
    assign flg[s+1] = flg_q;
  end

  assign valid_o  = v[W];
  assign q_re_o   = qre[W];
  assign q_im_o   = qim[W];
  assign res_re_o = sre[W];
  assign res_im_o = sim[W];
  assign flags_o  = flg[W];

endmodule

### bench/cau_scoreboard.sv
// Checker for complex_arith_unit: watches both stream channels, predicts each
// result word from the accepted input word and compares in order. Needs cau_pkg.
`timescale 1ns / 100ps

module cau_scoreboard import cau_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_ready_i,
  input  logic [135:0] in_data_i,
  input  logic         out_valid_i,
  input  logic         out_ready_i,
  input  logic [71:0]  out_data_i,
  output int           fail_count_o,
  output int           pending_o
);

  typedef struct packed {
    logic [31:0] res_re;
    logic [31:0] res_im;
    logic        div_by_zero;
    logic        overflow;
    logic        mag_less;
    logic        mag_greater;
    logic        parts_equal;
    logic        a_is_zero;
  } cau_result_t;

  localparam logic signed [129:0] Q_MAX = 130'sh7fffffff;
  localparam logic signed [129:0] Q_MIN = -130'sh80000000;
  localparam logic signed [129:0] Q_ONE = 130'sd65536;

  cau_result_t expected_q[$];
  int          fails;

  // clamp to the signed 32-bit range, noting any clipping
  function automatic logic [31:0] clamp_word(input logic signed [129:0] v,
                                             inout logic clipped);
    if (v > Q_MAX) begin
      clipped = 1'b1;
      return Q_MAX[31:0];
    end
    if (v < Q_MIN) begin
      clipped = 1'b1;
      return Q_MIN[31:0];
    end
    return v[31:0];
  endfunction

  // exact-arithmetic prediction of one result word
  function automatic cau_result_t complex_result(input logic [135:0] w);
    cmd_e                   op;
    logic signed [129:0]    xr, xi, yr, yi, mag_a, mag_b, rr, ri;
    logic                   clip;
    cau_result_t            r;
    op    = cmd_e'(w[2:0]);
    xr    = $signed(w[34:3]);
    xi    = $signed(w[66:35]);
    yr    = $signed(w[98:67]);
    yi    = $signed(w[130:99]);
    mag_a = xr * xr + xi * xi;
    mag_b = yr * yr + yi * yi;
    rr    = '0;
    ri    = '0;
    clip  = 1'b0;
    r     = '0;
    case (op)
      CMD_ADD: begin
        rr = xr + yr; ri = xi + yi;
      end
      CMD_SUB: begin
        rr = xr - yr; ri = xi - yi;
      end
      CMD_MUL: begin
        rr = (xr * yr - xi * yi) >>> 16;
        ri = (xr * yi + xi * yr) >>> 16;
      end
      CMD_DIV: begin
        if (mag_b == 0) begin
          r.div_by_zero = 1'b1;
        end else begin
          // signed division truncates toward zero
          rr = ((xr * yr + xi * yi) <<< 16) / mag_b;
          ri = ((xi * yr - xr * yi) <<< 16) / mag_b;
        end
      end
      CMD_NEG: begin
        rr = -xr; ri = -xi;
      end
      CMD_CMP: ;
      CMD_INC: begin
        rr = xr + Q_ONE; ri = xi;
      end
      default: begin
        rr = xr - Q_ONE; ri = xi;
      end
    endcase
    r.res_re      = clamp_word(rr, clip);
    r.res_im      = clamp_word(ri, clip);
    r.overflow    = clip;
    r.mag_less    = mag_a < mag_b;
    r.mag_greater = mag_a > mag_b;
    r.parts_equal = (xr == yr) && (xi == yi);
    r.a_is_zero   = (xr == 0) && (xi == 0);
    return r;
  endfunction

  function automatic int field_diff(input string name, input logic [31:0] exp_v,
                                    input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  // watch both channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    cau_result_t exp_r, got;
    int          n;
    if (!rst_ni) begin
      fails = 0;
    end else begin
      if (in_valid_i && in_ready_i) expected_q.push_back(complex_result(in_data_i));
      if (out_valid_i && out_ready_i) begin
        got = {out_data_i[31:0], out_data_i[63:32], out_data_i[64], out_data_i[65],
               out_data_i[66], out_data_i[67], out_data_i[68], out_data_i[69]};
        if (expected_q.size() == 0) begin
          $error("result word with no expectation waiting: %h", out_data_i);
          fails++;
        end else begin
          exp_r = expected_q.pop_front();
          n = field_diff("res_re", exp_r.res_re, got.res_re)
            + field_diff("res_im", exp_r.res_im, got.res_im)
            + field_diff("div_by_zero", exp_r.div_by_zero, got.div_by_zero)
            + field_diff("overflow", exp_r.overflow, got.overflow)
            + field_diff("mag_less", exp_r.mag_less, got.mag_less)
            + field_diff("mag_greater", exp_r.mag_greater, got.mag_greater)
            + field_diff("parts_equal", exp_r.parts_equal, got.parts_equal)
            + field_diff("a_is_zero", exp_r.a_is_zero, got.a_is_zero);
          if (n != 0) fails++;
        end
      end
    end
    pending_o = expected_q.size();
  end

  assign fail_count_o = fails;

endmodule

### bench/tb_complex_arith_unit.sv
// Top of the complex_arith_unit bench: clock, reset, operand stimulus and
// output backpressure; verdict from cau_scoreboard. Needs cau_pkg and the RTL.
`timescale 1ns / 100ps

module tb_complex_arith_unit;
  import cau_pkg::*;

  localparam logic [31:0] W_MAX = 32'h7fffffff;
  localparam logic [31:0] W_MIN = 32'h80000000;
  localparam logic [31:0] W_ONE = 32'h00010000;
  localparam int N_RANDOM = 530;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;  // command, a_re, a_im, b_re, b_im, pad
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;       // res_re, res_im, six flags, pad
  int           fail_count, pending;
  int           words_sent = 0;
  int           send_idle_pct = 29;
  int           recv_idle_pct = 60;
  int           hold_left = 0;
  bit           hold_done = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  complex_arith_unit uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  cau_scoreboard checker_i (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_i(s_axis_tready), .in_data_i(s_axis_tdata),
    .out_valid_i(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_i(m_axis_tdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stalls, plus one long hold-off to back up the pipe
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && words_sent >= 400) begin
      hold_done <= 1'b1;
      hold_left <= 150;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one word onto the input channel, holding until accepted
  task automatic send_word(input cmd_e op, input logic [31:0] ar, input logic [31:0] ai,
                           input logic [31:0] br, input logic [31:0] bi);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, bi, br, ai, ar, op};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    words_sent++;
    if (words_sent == 180) begin
      send_idle_pct = 60;
      recv_idle_pct = 29;
    end else if (words_sent == 360) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // operand mix: extremes, small values and full-range values
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0:       return W_MAX;
      1:       return W_MIN;
      2:       return '0;
      3:       return W_ONE;
      4, 5:    return $urandom_range(32'h000fffff) - 32'h00080000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] ar, ai, br, bi;
    cmd_e        op;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, each command, zero divisor, scalar and equal forms
    send_word(CMD_ADD, W_MAX, W_MAX, W_MAX, W_ONE);
    send_word(CMD_ADD, W_MIN, W_MIN, W_MIN, '0);
    send_word(CMD_SUB, W_MIN, W_MAX, W_MAX, W_MIN);
    send_word(CMD_SUB, W_ONE, '0, W_ONE, '0);
    send_word(CMD_MUL, W_MAX, W_MAX, W_MAX, W_MIN);
    send_word(CMD_MUL, W_MIN, '0, W_MIN, '0);
    send_word(CMD_MUL, 32'hffff8000, W_ONE, 32'h00018000, '0);
    send_word(CMD_DIV, W_ONE, W_ONE, '0, '0);
    send_word(CMD_DIV, '0, '0, '0, '0);
    send_word(CMD_DIV, W_MAX, W_MIN, 32'h00000001, '0);
    send_word(CMD_DIV, 32'h00030000, 32'hfffe0000, 32'h00010000, 32'h00020000);
    send_word(CMD_DIV, 32'hffffffff, '0, 32'h00030000, '0);
    send_word(CMD_NEG, W_MIN, W_MIN, '0, '0);
    send_word(CMD_NEG, W_MAX, 32'h00000001, W_MAX, 32'h00000001);
    send_word(CMD_CMP, W_ONE, '0, '0, W_ONE);
    send_word(CMD_CMP, W_MIN, W_MIN, W_MAX, W_MAX);
    send_word(CMD_CMP, '0, '0, '0, W_ONE);
    send_word(CMD_INC, W_MAX, W_MIN, '0, '0);
    send_word(CMD_INC, 32'hffff0000, W_ONE, 32'hffff0000, W_ONE);
    send_word(CMD_DEC, W_MIN, W_MAX, '0, '0);
    send_word(CMD_DEC, W_ONE, '0, W_ONE, '0);

    // random operand words
    repeat (N_RANDOM) begin
      op = cmd_e'($urandom_range(7));
      ar = pick_operand();
      ai = pick_operand();
      br = pick_operand();
      bi = ($urandom_range(3) == 0) ? '0 : pick_operand();
      case ($urandom_range(9))
        0: begin
          br = ar; bi = ai;
        end
        1: begin
          br = '0; bi = '0;
        end
        2: begin
          ar = '0; ai = '0;
        end
        default: ;
      endcase
      send_word(op, ar, ai, br, bi);
    end
    s_axis_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) $display("tb_complex_arith_unit: done, clean");
    else $display("tb_complex_arith_unit: done, errors");
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("tb_complex_arith_unit: done, errors");
    $finish;
  end

endmodule
